// ===== hw/rtl/tls_certificate_list_splitter_top_macros.svh =====
// Assertion macros used by the certificate splitter queue.
`ifndef TLS_CERTIFICATE_LIST_SPLITTER_TOP_MACROS_SVH
`define TLS_CERTIFICATE_LIST_SPLITTER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define TLCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define TLCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tlcs_pkg.sv =====
// Shared types and constants for the certificate list splitter.
package tlcs_pkg;

  localparam int unsigned LenW       = 24;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned IdxW       = 8;
  localparam int unsigned QueueDepth = 2;

  // One result item as it moves from parser to output stage.
  typedef struct packed {
    logic [ByteW-1:0] cert_byte;
    logic             byte_valid;
    logic [IdxW-1:0]  cert_index;
    logic             cert_end;
    logic             list_end;
    logic             overrun;
  } res_t;

  // Queue status seen by the parser and the output stage.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== hw/rtl/tlcs_parser.sv =====
// Front end: accepts message bytes, tracks the parse and classifies results.
module tlcs_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tlcs_pkg::ByteW-1:0]   data_byte_i,
  input  logic                         start_req_i,
  input  tlcs_pkg::qstat_t             qstat_i,
  output logic                         push_o,
  output tlcs_pkg::res_t               push_data_o
);
  import tlcs_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_LIST = 3'd2;
  localparam logic [2:0] PH_CLEN = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;
  localparam logic [2:0] PH_ERR  = 3'd6;

  localparam logic [1:0] HDR_LAST = 2'd3;
  localparam logic [1:0] LEN_LAST = 2'd2;

  logic [2:0]      phase_q, phase_d;
  logic [1:0]      bc_q, bc_d;
  logic [LenW-1:0] acc_q, acc_d;
  logic [LenW-1:0] lr_q, lr_d;
  logic [LenW-1:0] cr_q, cr_d;
  logic [IdxW-1:0] cc_q, cc_d;

  logic [2:0]      ph;
  logic [1:0]      bc;
  logic [LenW-1:0] acc, lr, cr, acc_sh, lr_dec, cr_dec;
  logic [IdxW-1:0] cc, cc_inc;
  logic            emit;
  res_t            res;
  logic            accept;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ph  = phase_q;
    bc  = bc_q;
    acc = acc_q;
    lr  = lr_q;
    cr  = cr_q;
    cc  = cc_q;
    // start flag restarts the parse on this very byte
    if (start_req_i) begin
      ph  = PH_HDR;
      bc  = '0;
      acc = '0;
      lr  = '0;
      cr  = '0;
      cc  = '0;
    end

    acc_sh = {acc[LenW-ByteW-1:0], data_byte_i};
    lr_dec = (lr != '0) ? lr - 1'b1 : lr;
    cr_dec = (cr != '0) ? cr - 1'b1 : cr;
    cc_inc = (cc != '1) ? cc + 1'b1 : cc;

    phase_d = ph;
    bc_d    = bc;
    acc_d   = acc;
    lr_d    = lr;
    cr_d    = cr;
    cc_d    = cc;
    emit    = 1'b0;
    res     = '0;
    res.cert_index = cc;

    unique case (ph)
      PH_HDR: begin
        if (bc == HDR_LAST) begin
          bc_d    = '0;
          acc_d   = '0;
          phase_d = PH_LIST;
        end else begin
          bc_d = bc + 1'b1;
        end
      end
      PH_LIST: begin
        acc_d = acc_sh;
        if (bc == LEN_LAST) begin
          lr_d    = acc_sh;
          acc_d   = '0;
          bc_d    = '0;
          phase_d = (acc_sh != '0) ? PH_CLEN : PH_DONE;
        end else begin
          bc_d = bc + 1'b1;
        end
      end
      PH_CLEN: begin
        acc_d = acc_sh;
        lr_d  = lr_dec;
        if (bc == LEN_LAST) begin
          acc_d = '0;
          bc_d  = '0;
          if (acc_sh > lr_dec) begin
            emit        = 1'b1;
            res.overrun = 1'b1;
            phase_d     = PH_ERR;
          end else if (acc_sh == '0) begin
            // empty certificate: a single result with no data
            emit         = 1'b1;
            res.cert_end = 1'b1;
            res.list_end = (lr_dec == '0);
            cc_d         = cc_inc;
            phase_d      = (lr_dec == '0) ? PH_DONE : PH_CLEN;
          end else begin
            cr_d    = acc_sh;
            phase_d = PH_DATA;
          end
        end else begin
          bc_d = bc + 1'b1;
          // list ran out inside a length field
          if (lr_dec == '0) begin
            emit        = 1'b1;
            res.overrun = 1'b1;
            phase_d     = PH_ERR;
          end
        end
      end
      PH_DATA: begin
        cr_d           = cr_dec;
        lr_d           = lr_dec;
        emit           = 1'b1;
        res.cert_byte  = data_byte_i;
        res.byte_valid = 1'b1;
        res.cert_end   = (cr_dec == '0);
        res.list_end   = (lr_dec == '0);
        if (cr_dec == '0) begin
          cc_d    = cc_inc;
          phase_d = (lr_dec == '0) ? PH_DONE : PH_CLEN;
        end
      end
      default: begin
        // idle, done, error and unused codes ignore the byte
      end
    endcase
  end

  assign push_o      = accept && emit;
  assign push_data_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bc_q    <= '0;
      acc_q   <= '0;
      lr_q    <= '0;
      cr_q    <= '0;
      cc_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      acc_q   <= acc_d;
      lr_q    <= lr_d;
      cr_q    <= cr_d;
      cc_q    <= cc_d;
    end
  end

endmodule

// ===== hw/rtl/tlcs_queue.sv =====
// Short result queue between the parser and the output stage.
module tlcs_queue #(
  parameter int unsigned Depth = tlcs_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tlcs_pkg::res_t   push_data_i,
  input  logic             pop_i,
  output tlcs_pkg::res_t   pop_data_o,
  output tlcs_pkg::qstat_t qstat_o
);
  import tlcs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign qstat_o.full  = (count_q == CntFull);
  assign qstat_o.empty = (count_q == '0);
  assign pop_data_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`include "tls_certificate_list_splitter_top_macros.svh"

  `TLCS_ASSERT_NOW(a_no_push_full, push_i, !qstat_o.full || pop_i, "push into full queue")
  `TLCS_ASSERT_NOW(a_no_pop_empty, pop_i, !qstat_o.empty, "pop from empty queue")
  `TLCS_ASSERT_NOW(a_count_range, 1'b1, count_q <= CntFull, "queue count out of range")
  `TLCS_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == CntW'($past(count_q) + 1'b1), "count not incremented")

endmodule

// ===== hw/rtl/tlcs_out.sv =====
// Back end: output register that drains the queue onto the result stream.
module tlcs_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlcs_pkg::qstat_t qstat_i,
  input  tlcs_pkg::res_t   pop_data_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // cert_byte[7:0], cert_index[15:8]
  output logic             m_axis_tlast,   // cert_end
  output logic [2:0]       m_axis_tuser    // byte_valid[0], list_end[1], overrun[2]
);
  import tlcs_pkg::*;

  res_t out_q;
  logic valid_q;

  assign pop_o = !qstat_i.empty && (!valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= pop_data_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {out_q.cert_index, out_q.cert_byte};
  assign m_axis_tlast  = out_q.cert_end;
  assign m_axis_tuser  = {out_q.overrun, out_q.list_end, out_q.byte_valid};

endmodule

// ===== hw/rtl/tls_certificate_list_splitter_top.sv =====
// Throughput: one byte per cycle while the queue is not full; the parser registers its
// counters on each accepted byte. A byte's result is written to the queue when the byte
// is accepted and then loaded into the output register, which drives m_axis_tvalid; a
// stalled output fills the queue and then drops s_axis_tready.
// Reset: rst_ni is asynchronous, active low; it idles the parser (waits for a start
// byte), clears its counters, empties the queue and clears the output valid.
module tls_certificate_list_splitter_top #(
  parameter int unsigned QueueDepth = tlcs_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tuser,   // start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // cert_byte[7:0], cert_index[15:8]
  output logic        m_axis_tlast,   // cert_end
  output logic [2:0]  m_axis_tuser    // byte_valid[0], list_end[1], overrun[2]
);
  import tlcs_pkg::*;

  qstat_t qstat;
  logic   push, pop;
  res_t   push_data, pop_data;

  tlcs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .data_byte_i (s_axis_tdata),
    .start_req_i (s_axis_tuser),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tlcs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .qstat_o     (qstat)
  );

  tlcs_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
